/* rtl/cmhb_pkg.sv */
// Shared constants, widths and types of the CMH minimum p-value bound block.
// No dependencies.
package cmhb_pkg;

    localparam int MAX_TABLES = 16;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int CNT_W    = $clog2(MAX_TABLES + 1);
    localparam int IDX_W    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int FW       = 16 + FRAC_BITS;
    localparam int FSW      = FW + CNT_W;
    localparam int OPW      = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
    localparam int MD_CNT_W = $clog2(OPW + 1);
    localparam int STAT_W   = 48;
    localparam int DRAIN    = 2 * MAX_TABLES + 4;
    localparam int DRN_W    = $clog2(DRAIN + 1);

    localparam logic [15:0] CNT_MASK = 16'(((64'd1 << COUNT_BITS) - 64'd1) & 64'hFFFF);

    typedef struct packed {
        logic [31:0]   p;
        logic [31:0]   q;
        logic [FW-1:0] f;
        logic [FW-1:0] g;
    } t_item;

    typedef struct packed {
        logic clear;
        logic shift;
        logic act;
    } t_cell_ctl;

endpackage

/* rtl/cmhb_muldiv.sv */
// Serial floor(a*b/d): shift-add multiply, then restoring division, one bit a cycle.
// Quotient saturates to all ones on overflow or a zero divisor. Uses cmhb_pkg.
module cmhb_muldiv import cmhb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [OPW-1:0] i_a,
    input  logic [OPW-1:0] i_b,
    input  logic [OPW-1:0] i_d,
    output logic           o_done,
    output logic [OPW-1:0] o_quot
);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_CHK, MD_DIV} t_md_state;

    t_md_state             r_state;
    logic [2*OPW-1:0]      r_acc;
    logic [OPW-1:0]        r_a;
    logic [OPW-1:0]        r_b;
    logic [OPW-1:0]        r_d;
    logic [MD_CNT_W-1:0]   r_cnt;
    logic                  r_done;

    logic [OPW:0] w_t;
    logic         w_ge;
    logic [OPW:0] w_r;

    assign w_t  = {r_acc[2*OPW-1:OPW], r_acc[OPW-1]};
    assign w_ge = w_t >= {1'b0, r_d};
    assign w_r  = w_ge ? (w_t - {1'b0, r_d}) : w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                MD_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_d     <= i_d;
                        r_cnt   <= MD_CNT_W'(OPW);
                        r_state <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_acc <= (r_acc << 1) + (r_b[OPW-1] ? {{OPW{1'b0}}, r_a} : '0);
                    r_b   <= r_b << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == MD_CNT_W'(1)) r_state <= MD_CHK;
                end
                MD_CHK: begin
                    if (r_d == '0 || r_acc[2*OPW-1:OPW] >= r_d) begin
                        r_acc[OPW-1:0] <= '1;
                        r_done         <= 1'b1;
                        r_state        <= MD_IDLE;
                    end else begin
                        r_cnt   <= MD_CNT_W'(OPW);
                        r_state <= MD_DIV;
                    end
                end
                MD_DIV: begin
                    r_acc <= {w_r[OPW-1:0], r_acc[OPW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == MD_CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[OPW-1:0];

endmodule

/* rtl/cmhb_cell.sv */
// One cell of the systolic insertion-sort chain: holds one entry, keeps the
// smaller key by exact cross-multiplication, passes the other on. Uses cmhb_pkg.
module cmhb_cell import cmhb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_in_valid,
    input  t_item     i_in,
    input  logic      i_nxt_valid,
    input  t_item     i_nxt,
    output logic      o_out_valid,
    output t_item     o_out,
    output logic      o_st_valid,
    output t_item     o_st
);

    logic [63:0] r_pa;
    logic [63:0] r_pb;
    logic        r_vld;
    logic        r_ovld;
    t_item       r_st;
    t_item       r_out;

    // products settle on the off-phase, used on the act phase
    always_ff @(posedge i_clk) begin
        r_pa <= i_in.p * r_st.q;
        r_pb <= r_st.p * i_in.q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld  <= 1'b0;
            r_ovld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_nxt_valid;
            r_st  <= i_nxt;
        end else if (i_ctl.act) begin
            if (i_in_valid) begin
                if (!r_vld) begin
                    r_st   <= i_in;
                    r_vld  <= 1'b1;
                    r_ovld <= 1'b0;
                end else if (r_pa < r_pb) begin
                    r_out  <= r_st;
                    r_st   <= i_in;
                    r_ovld <= 1'b1;
                end else begin
                    r_out  <= i_in;
                    r_ovld <= 1'b1;
                end
            end else begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;
    assign o_st_valid  = r_vld;
    assign o_st        = r_st;

endmodule

/* rtl/cmh_min_pvalue_bound.sv */
// Top level: table store, corner check, sequencer, sort chain and mul-div unit.
// Uses cmhb_pkg, cmhb_cell, cmhb_muldiv.
//
// Tables are taken one per cycle; a transaction with i_last_table set starts the
// evaluation and o_stall stays high until the result is loaded into the output
// register. The evaluation runs the left side then the right side. Per side, each
// kept table takes two passes through the shared serial mul-div unit (OPW = 48
// here), the sort chain is then left to settle, and each sorted entry with a non-zero
// running g sum takes one more pass for its prefix quotient. A failed corner check
// skips both sides and goes straight from the last table to the output state.
module cmh_min_pvalue_bound import cmhb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [15:0]       i_table_margin,
    input  logic [15:0]       i_class_positives,
    input  logic [15:0]       i_class_total,
    input  logic              i_last_table,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_corner_ok,
    output logic [STAT_W-1:0] o_stat_left,
    output logic [STAT_W-1:0] o_stat_right,
    output logic [STAT_W-1:0] o_stat_max
);

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_FETCH, S_PREP, S_PREP2, S_FWAIT, S_GWAIT, S_INJ,
        S_DRAIN, S_SCAN, S_SCHK, S_SWAIT, S_SEND, S_OUT
    } t_state;

    t_state             r_state;
    logic [47:0]        r_store [MAX_TABLES];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_corner;
    logic               r_final_ok;
    logic               r_side;
    logic               r_phase;
    logic [15:0]        r_x;
    logic [15:0]        r_n;
    logic [15:0]        r_nn;
    logic [31:0]        r_m1;
    logic [31:0]        r_m2;
    logic [31:0]        r_nsq;
    logic [47:0]        r_ncube;
    logic [31:0]        r_p;
    logic [FW-1:0]      r_f;
    logic [FW-1:0]      r_g;
    logic               r_inj_valid;
    t_item              r_inj;
    logic [DRN_W-1:0]   r_wait;
    logic [FSW-1:0]     r_fs;
    logic [FSW-1:0]     r_gs;
    logic [STAT_W-1:0]  r_best;
    logic [STAT_W-1:0]  r_left;
    logic [STAT_W-1:0]  r_right;
    logic               r_md_start;
    logic [OPW-1:0]     r_md_a;
    logic [OPW-1:0]     r_md_b;
    logic [OPW-1:0]     r_md_d;
    logic               r_o_valid;
    logic               r_o_ok;
    logic [STAT_W-1:0]  r_o_left;
    logic [STAT_W-1:0]  r_o_right;
    logic [STAT_W-1:0]  r_o_max;

    logic [15:0]       w_x;
    logic [15:0]       w_n;
    logic [15:0]       w_nn;
    logic [15:0]       w_bnd;
    logic              w_ok;
    logic              w_acc;
    logic [15:0]       w_c;
    logic [15:0]       w_oth;
    logic              w_md_done;
    logic [OPW-1:0]    w_md_q;
    logic [STAT_W-1:0] w_sat;
    t_cell_ctl         w_ctl;

    logic  w_vin [MAX_TABLES+1];
    t_item w_in  [MAX_TABLES+1];
    logic  w_sv  [MAX_TABLES+1];
    t_item w_st  [MAX_TABLES+1];

    assign w_x   = i_table_margin & CNT_MASK;
    assign w_n   = i_class_positives & CNT_MASK;
    assign w_nn  = i_class_total & CNT_MASK;
    assign w_bnd = (w_n > w_nn - w_n) ? w_n : (w_nn - w_n);
    assign w_ok  = (w_nn != '0) && (w_n <= w_nn) && (w_x >= w_bnd);
    assign w_acc = i_valid && !o_stall;

    assign w_c   = r_side ? (r_nn - r_n) : r_n;
    assign w_oth = r_side ? r_n : (r_nn - r_n);
    assign w_sat = (w_md_q > OPW'({STAT_W{1'b1}})) ? {STAT_W{1'b1}} : w_md_q[STAT_W-1:0];

    always_comb begin
        w_ctl.clear = (r_state == S_CLR);
        w_ctl.shift = (r_state == S_SCAN) && w_sv[0];
        w_ctl.act   = r_phase;
    end

    assign w_vin[0] = r_inj_valid;
    assign w_in[0]  = r_inj;
    assign w_sv[MAX_TABLES] = 1'b0;
    assign w_st[MAX_TABLES] = '0;

    for (genvar k = 0; k < MAX_TABLES; k++) begin : g_chain
        cmhb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_in_valid  (w_vin[k]),
            .i_in        (w_in[k]),
            .i_nxt_valid (w_sv[k+1]),
            .i_nxt       (w_st[k+1]),
            .o_out_valid (w_vin[k+1]),
            .o_out       (w_in[k+1]),
            .o_st_valid  (w_sv[k]),
            .o_st        (w_st[k])
        );
    end

    cmhb_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_a     (r_md_a),
        .i_b     (r_md_b),
        .i_d     (r_md_d),
        .o_done  (w_md_done),
        .o_quot  (w_md_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_corner    <= 1'b1;
            r_phase     <= 1'b0;
            r_inj_valid <= 1'b0;
            r_md_start  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_phase <= ~r_phase;
            if (r_phase && r_state != S_INJ) r_inj_valid <= 1'b0;
            if (r_o_valid && !i_stall && r_state != S_OUT) r_o_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (r_count < CNT_W'(MAX_TABLES)) begin
                            r_store[r_count[IDX_W-1:0]] <= {w_nn, w_n, w_x};
                            r_count  <= r_count + 1'b1;
                            r_corner <= r_corner & w_ok;
                        end
                        if (i_last_table) begin
                            r_final_ok <= r_corner &
                                          (w_ok || (r_count >= CNT_W'(MAX_TABLES)));
                            r_side     <= 1'b0;
                            r_left     <= '0;
                            r_right    <= '0;
                            if (r_corner && (w_ok || (r_count >= CNT_W'(MAX_TABLES))))
                                r_state <= S_CLR;
                            else
                                r_state <= S_OUT;
                        end
                    end
                end
                S_CLR: begin
                    r_idx   <= '0;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    if (r_idx == r_count) begin
                        r_wait  <= DRN_W'(DRAIN);
                        r_state <= S_DRAIN;
                    end else begin
                        r_x     <= r_store[r_idx[IDX_W-1:0]][15:0];
                        r_n     <= r_store[r_idx[IDX_W-1:0]][31:16];
                        r_nn    <= r_store[r_idx[IDX_W-1:0]][47:32];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_x >= r_nn || w_c == '0) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_FETCH;
                    end else begin
                        r_m1    <= r_n * (r_nn - r_n);
                        r_m2    <= r_x * (r_nn - r_x);
                        r_nsq   <= r_nn * r_nn;
                        r_p     <= w_oth * r_x;
                        r_state <= S_PREP2;
                    end
                end
                S_PREP2: begin
                    r_ncube    <= 48'(r_nsq) * 48'(r_nn);
                    r_md_a     <= OPW'(w_c);
                    r_md_b     <= OPW'(r_nn - r_x) << FRAC_BITS;
                    r_md_d     <= OPW'(r_nn);
                    r_md_start <= 1'b1;
                    r_state    <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (w_md_done) begin
                        r_f        <= FW'(w_md_q);
                        r_md_a     <= OPW'(r_m1);
                        r_md_b     <= OPW'(r_m2) << FRAC_BITS;
                        r_md_d     <= OPW'(r_ncube);
                        r_md_start <= 1'b1;
                        r_state    <= S_GWAIT;
                    end else begin
                        r_md_start <= 1'b0;
                    end
                end
                S_GWAIT: begin
                    r_md_start <= 1'b0;
                    if (w_md_done) begin
                        r_g     <= FW'(w_md_q);
                        r_state <= S_INJ;
                    end
                end
                S_INJ: begin
                    if (r_phase) begin
                        r_inj       <= '{p: r_p, q: r_nsq, f: r_f, g: r_g};
                        r_inj_valid <= 1'b1;
                        r_idx       <= r_idx + 1'b1;
                        r_state     <= S_FETCH;
                    end
                end
                S_DRAIN: begin
                    if (r_wait == '0) begin
                        r_fs    <= '0;
                        r_gs    <= '0;
                        r_best  <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_sv[0]) begin
                        r_fs    <= r_fs + FSW'(w_st[0].f);
                        r_gs    <= r_gs + FSW'(w_st[0].g);
                        r_state <= S_SCHK;
                    end else begin
                        r_state <= S_SEND;
                    end
                end
                S_SCHK: begin
                    if (r_gs == '0) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_md_a     <= OPW'(r_fs);
                        r_md_b     <= OPW'(r_fs);
                        r_md_d     <= OPW'(r_gs);
                        r_md_start <= 1'b1;
                        r_state    <= S_SWAIT;
                    end
                end
                S_SWAIT: begin
                    r_md_start <= 1'b0;
                    if (w_md_done) begin
                        if (w_sat > r_best) r_best <= w_sat;
                        r_state <= S_SCAN;
                    end
                end
                S_SEND: begin
                    if (!r_side) begin
                        r_left  <= r_best;
                        r_side  <= 1'b1;
                        r_state <= S_CLR;
                    end else begin
                        r_right <= r_best;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_ok    <= r_final_ok;
                        r_o_left  <= r_left;
                        r_o_right <= r_right;
                        r_o_max   <= (r_left > r_right) ? r_left : r_right;
                        r_count   <= '0;
                        r_corner  <= 1'b1;
                        r_state   <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = r_o_valid;
    assign o_corner_ok  = r_o_ok;
    assign o_stat_left  = r_o_left;
    assign o_stat_right = r_o_right;
    assign o_stat_max   = r_o_max;

endmodule

/* rtl/cmhb_checker.sv */
// Port-level checks for cmh_min_pvalue_bound, attached by bind.
// Uses cmhb_pkg.
module cmhb_checker import cmhb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [15:0]       i_table_margin,
    input logic [15:0]       i_class_positives,
    input logic [15:0]       i_class_total,
    input logic              i_last_table,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_corner_ok,
    input logic [STAT_W-1:0] o_stat_left,
    input logic [STAT_W-1:0] o_stat_right,
    input logic [STAT_W-1:0] o_stat_max
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_stat_max) && $stable(o_corner_ok))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_corner_ok |-> o_stat_left == '0 && o_stat_right == '0 &&
                                    o_stat_max == '0)
        else $error("non-zero statistic on corner failure");

    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stat_max == ((o_stat_left > o_stat_right) ? o_stat_left : o_stat_right))
        else $error("stat_max is not the larger side");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

endmodule

bind cmh_min_pvalue_bound cmhb_checker u_cmhb_checker (.*);

/* test/cmh_min_pvalue_bound_check.sv */
`timescale 1ns / 1ps
// Checker for cmh_min_pvalue_bound: watches both channels, predicts each result
// and compares it field by field. Uses cmhb_pkg for the stat width, table limit and fraction bits.
module cmh_min_pvalue_bound_check import cmhb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic [15:0]       i_table_margin,
    input  logic [15:0]       i_class_positives,
    input  logic [15:0]       i_class_total,
    input  logic              i_last_table,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic              o_corner_ok,
    input  logic [STAT_W-1:0] o_stat_left,
    input  logic [STAT_W-1:0] o_stat_right,
    input  logic [STAT_W-1:0] o_stat_max,
    output int                fail_count,
    output int                pending
);

    localparam logic [63:0] STAT_SAT = (64'd1 << STAT_W) - 64'd1;

    typedef struct packed {
        logic              corner_ok;
        logic [STAT_W-1:0] left;
        logic [STAT_W-1:0] right;
        logic [STAT_W-1:0] maxv;
    } t_bound;

    logic [15:0] tbl_x [MAX_TABLES];
    logic [15:0] tbl_n [MAX_TABLES];
    logic [15:0] tbl_t [MAX_TABLES];
    int          tbl_cnt;
    logic        corner;
    t_bound      bound_q [$];

    function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] d);
        logic [127:0] pr;
        logic [127:0] qt;
        if (d == 0) return '1;
        pr = {64'd0, a} * {64'd0, b};
        qt = pr / {64'd0, d};
        if (qt[127:64] != 0) return '1;
        return qt[63:0];
    endfunction

    function automatic logic [63:0] side_bound(bit right);
        logic [63:0] fa [MAX_TABLES];
        logic [63:0] ga [MAX_TABLES];
        logic [63:0] pa [MAX_TABLES];
        logic [63:0] qa [MAX_TABLES];
        logic [63:0] x, n, t, c, f, g, p, q, fs, gs, v, best;
        int cnt, k;
        cnt = 0;
        for (int i = 0; i < tbl_cnt; i++) begin
            x = tbl_x[i];
            n = tbl_n[i];
            t = tbl_t[i];
            if (x >= t || n > t) continue;
            c = right ? (t - n) : n;
            if (c == 0) continue;
            f = scaled_quot(c, (t - x) << FRAC_BITS, t);
            g = scaled_quot(n * (t - n), (x * (t - x)) << FRAC_BITS, t * t * t);
            p = (right ? n : (t - n)) * x;
            q = t * t;
            k = cnt;
            while (k > 0 && p * qa[k-1] < pa[k-1] * q) begin
                fa[k] = fa[k-1]; ga[k] = ga[k-1]; pa[k] = pa[k-1]; qa[k] = qa[k-1];
                k--;
            end
            fa[k] = f; ga[k] = g; pa[k] = p; qa[k] = q;
            cnt++;
        end
        fs = 0; gs = 0; best = 0;
        for (int i = 0; i < cnt; i++) begin
            fs += fa[i];
            gs += ga[i];
            if (gs == 0) continue;
            v = scaled_quot(fs, fs, gs);
            if (v > STAT_SAT) v = STAT_SAT;
            if (v > best) best = v;
        end
        return best;
    endfunction

    assign pending = bound_q.size();

    always @(posedge i_clk) begin
        logic        ok;
        logic [15:0] bnd;
        logic [63:0] l, r;
        t_bound      e;
        if (!i_rst_n) begin
            tbl_cnt    = 0;
            corner     = 1'b1;
            fail_count <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                ok = corner;
                if (tbl_cnt < MAX_TABLES) begin
                    if (i_class_total == 0 || i_class_positives > i_class_total) begin
                        ok = 1'b0;
                    end else begin
                        bnd = (i_class_positives > i_class_total - i_class_positives) ?
                              i_class_positives : i_class_total - i_class_positives;
                        if (i_table_margin < bnd) ok = 1'b0;
                    end
                    tbl_x[tbl_cnt] = i_table_margin;
                    tbl_n[tbl_cnt] = i_class_positives;
                    tbl_t[tbl_cnt] = i_class_total;
                    tbl_cnt = tbl_cnt + 1;
                end
                corner = ok;
                if (i_last_table) begin
                    l = 0; r = 0;
                    if (corner) begin
                        l = side_bound(1'b0);
                        r = side_bound(1'b1);
                    end
                    e.corner_ok = corner;
                    e.left      = l[STAT_W-1:0];
                    e.right     = r[STAT_W-1:0];
                    e.maxv      = (l > r) ? l[STAT_W-1:0] : r[STAT_W-1:0];
                    bound_q.push_back(e);
                    tbl_cnt = 0;
                    corner  = 1'b1;
                end
            end
            if (o_valid && !i_stall) begin
                if (bound_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction at %0t", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    e = bound_q.pop_front();
                    if (e.corner_ok !== o_corner_ok || e.left !== o_stat_left ||
                        e.right !== o_stat_right || e.maxv !== o_stat_max) begin
                        if (fail_count < 10)
                            $display({"mismatch at %0t: exp ok=%0d l=%0h r=%0h m=%0h, ",
                                      "got ok=%0d l=%0h r=%0h m=%0h"},
                                     $realtime, e.corner_ok, e.left, e.right, e.maxv,
                                     o_corner_ok, o_stat_left, o_stat_right, o_stat_max);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/cmh_min_pvalue_bound_test.sv */
`timescale 1ns / 1ps
// Testbench top for cmh_min_pvalue_bound: clock, reset, table stimulus and
// result back-pressure. Uses cmhb_pkg and cmh_min_pvalue_bound_check.
module cmh_min_pvalue_bound_test;
    import cmhb_pkg::*;

    localparam int NUM_ITEMS   = 1100;
    localparam int CYCLE_LIMIT = 8000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [15:0]       i_table_margin = '0;
    logic [15:0]       i_class_positives = '0;
    logic [15:0]       i_class_total = 16'd1;
    logic              i_last_table = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_corner_ok;
    logic [STAT_W-1:0] o_stat_left, o_stat_right, o_stat_max;
    int                fail_count, pending;
    int                cycles = 0;
    int                tx_gap_max = 15;
    int                rx_gap_max = 15;
    int                rx_wait = 0;
    logic              rx_taken = 1'b0;
    int                sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cmh_min_pvalue_bound u_top (.*);

    cmh_min_pvalue_bound_check u_check (.*);

    always @(posedge i_clk) begin
        cycles   <= cycles + 1;
        rx_taken <= o_valid && !i_stall;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (rx_taken) rx_wait = $urandom_range(rx_gap_max, 0);
        if (rx_wait > 0) begin
            i_stall = 1'b1;
            rx_wait--;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_table(logic [15:0] x, logic [15:0] n, logic [15:0] t, logic last);
        int gap;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_table_margin    = x;
        i_class_positives = n;
        i_class_total     = t;
        i_last_table      = last;
        i_valid           = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // corner-valid table; big selects full-range totals
    task automatic send_corner(bit big, logic last);
        logic [15:0] t, n, lo;
        t  = big ? 16'($urandom_range(65535, 1)) : 16'($urandom_range(40, 1));
        n  = 16'($urandom_range(t, 0));
        lo = (n > t - n) ? n : t - n;
        case ($urandom_range(3, 0))
            0:       send_table(t, n, t, last);
            1:       send_table(lo, n, t, last);
            default: send_table(16'($urandom_range(t, lo)), n, t, last);
        endcase
    endtask

    task automatic send_noise(logic last);
        case ($urandom_range(2, 0))
            0: send_table(16'($urandom), 16'($urandom), 16'd0, last);
            1: send_table(16'($urandom), 16'hFFFF, 16'($urandom_range(65534, 1)), last);
            2: send_table(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
                          last);
            default: ;
        endcase
    endtask

    initial begin
        int len;
        bit big;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_table(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        send_table(16'd1, 16'd0, 16'd1, 1'b1);
        send_table(16'd1, 16'd1, 16'd2, 1'b1);
        send_table(16'd32768, 16'd32767, 16'hFFFF, 1'b1);
        send_table(16'd40000, 16'd32767, 16'hFFFF, 1'b0);
        send_table(16'd40000, 16'd32768, 16'hFFFF, 1'b0);
        send_table(16'd3, 16'd3, 16'd5, 1'b1);
        send_table(16'd5, 16'd0, 16'd0, 1'b1);
        send_table(16'd9, 16'd10, 16'd9, 1'b1);
        send_table(16'd2, 16'd2, 16'd10, 1'b1);
        send_table(16'd4, 16'd4, 16'd4, 1'b0);
        send_table(16'd3, 16'd0, 16'd4, 1'b1);
        for (int i = 0; i < 17; i++) send_corner(i[0], 1'b0);
        send_table(16'd0, 16'd5, 16'd0, 1'b1);

        while (sent < NUM_ITEMS) begin
            tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
            rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 15;
            len = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            big = 1'($urandom_range(1, 0));
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9, 0) == 0) send_noise(i == len - 1);
                else send_corner(big, i == len - 1);
            end
        end
        i_valid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
